// ===== rtl/three_channel_note_sequencer_top_assert.svh =====
// Assertion helpers shared by the sequencer modules.
// Both expect clk and rst in scope.
`ifndef THREE_CHANNEL_NOTE_SEQUENCER_TOP_ASSERT_SVH
`define THREE_CHANNEL_NOTE_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication
`define TCNS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcns assertion failed");

// next-cycle implication
`define TCNS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcns assertion failed");

`endif

// ===== rtl/tcns_pkg.sv =====
package tcns_pkg;

  localparam int PATTERN_DEPTH = 128;
  localparam int PAT_AW        = $clog2(PATTERN_DEPTH);
  localparam int NOTE_COUNT    = 72;
  localparam int CMDQ_DEPTH    = 4;
  localparam int CMDQ_AW       = $clog2(CMDQ_DEPTH);
  localparam int OUTQ_DEPTH    = 4;
  localparam int OUTQ_AW       = $clog2(OUTQ_DEPTH);

  // item kinds
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // channel codes
  localparam logic [1:0] CHAN_TONE1 = 2'd0;
  localparam logic [1:0] CHAN_TONE2 = 2'd1;
  localparam logic [1:0] CHAN_NOISE = 2'd2;

  // register indexes
  localparam logic REG_TICKS_PER_BEAT = 1'b0;
  localparam logic REG_PATTERN_LENGTH = 1'b1;

  localparam logic [7:0] TICKS_PER_BEAT_RESET = 8'd1;
  localparam logic [7:0] PATTERN_LENGTH_RESET = 8'd1;

  localparam logic [10:0] FREQ_TABLE [NOTE_COUNT] = '{
    11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
    11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
    11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
    11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
    11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
    11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
    11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
    11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
    11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
    11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
    11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
    11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
  };

  typedef struct packed {
    logic       cmd;
    logic [1:0] channel;
    logic [6:0] beat_index;
    logic [6:0] pitch;
    logic [7:0] duty;
    logic [7:0] envelope;
  } in_t;

  typedef struct packed {
    logic        tone1_on;
    logic [7:0]  tone1_duty;
    logic [7:0]  tone1_envelope;
    logic [10:0] tone1_freq;
    logic        tone2_on;
    logic [7:0]  tone2_duty;
    logic [7:0]  tone2_envelope;
    logic [10:0] tone2_freq;
    logic        noise_on;
    logic [7:0]  noise_length;
    logic [7:0]  noise_envelope;
    logic [10:0] noise_freq;
  } out_t;

  // operation passed from front to back
  typedef struct packed {
    logic       is_beat;
    logic [1:0] chan;
    logic [6:0] idx;
    logic [6:0] pitch;
    logic [7:0] duty;
    logic [7:0] env;
  } cmd_t;

  typedef struct packed {
    logic [6:0] pitch;
    logic [7:0] duty;
    logic [7:0] env;
  } entry_t;

  typedef struct packed {
    logic        on;
    logic [7:0]  duty;
    logic [7:0]  env;
    logic [10:0] freq;
  } chan_out_t;

  typedef struct packed {
    logic       load;
    logic [7:0] value;
  } tpb_wr_t;

  function automatic logic [10:0] note_freq(input logic [6:0] note);
    logic [10:0] f;
    f = 11'd0;
    if (note < 7'(NOTE_COUNT)) f = FREQ_TABLE[note];
    return f;
  endfunction

  function automatic chan_out_t channel_out(input entry_t e, input logic silent);
    chan_out_t c;
    c = '0;
    if (!silent && e.pitch < 7'(NOTE_COUNT)) begin
      c.on   = 1'b1;
      c.duty = e.duty;
      c.env  = e.env;
      c.freq = note_freq(e.pitch);
    end
    return c;
  endfunction

endpackage

// ===== rtl/three_channel_note_sequencer_top.sv =====
// Three-channel note step sequencer (two tone channels, one noise channel).
// Input queue side: push/full with payload item. A write item stores one
// pattern entry; a tick item advances the tick counter and, every
// ticks_per_beat ticks starting with the first, fires a beat.
// Result queue side: empty/pop with payload notes. One item per beat, giving
// on/duty/envelope/frequency for each channel; writes and other ticks give none.
// Config: cfg_we/cfg_index/cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it. Throughput: one item
// per cycle while full is low, set by the single-port pattern memories (one
// write or one beat read a cycle) and a 4-entry command queue.
// Writing ticks_per_beat starts a remainder recompute of the tick counter,
// during which full is high.
// Reset clears counters, queues and registers (both to 1); pattern entries are
// undefined until written. A stalled receiver fills the 4-entry result queue,
// then the command queue, and then full rises; nothing is dropped.
module three_channel_note_sequencer_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tcns_pkg::in_t   item,
  output logic            empty,
  input  logic            pop,
  output tcns_pkg::out_t  notes,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data
);

  logic [7:0] ticks_per_beat, pattern_length;
  tcns_pkg::tpb_wr_t tpb_wr;
  tcns_pkg::cmd_t q_in, q_head;
  logic q_push, q_full, q_pop, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_beat <= tcns_pkg::TICKS_PER_BEAT_RESET;
      pattern_length <= tcns_pkg::PATTERN_LENGTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcns_pkg::REG_TICKS_PER_BEAT: ticks_per_beat <= cfg_data;
        tcns_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data;
        default: ;
      endcase
    end
  end

  assign tpb_wr.load  = cfg_we && cfg_index == tcns_pkg::REG_TICKS_PER_BEAT;
  assign tpb_wr.value = cfg_data;

  tcns_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .tpb    (ticks_per_beat),
    .tpb_wr (tpb_wr),
    .q_push (q_push),
    .q_data (q_in),
    .q_full (q_full)
  );

  tcns_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  tcns_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .plen    (pattern_length),
    .pop     (pop),
    .empty   (empty),
    .notes   (notes)
  );

endmodule

// ===== rtl/tcns_cmd_queue.sv =====
module tcns_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcns_pkg::cmd_t  push_data,
  output logic            full,
  input  logic            pop,
  output tcns_pkg::cmd_t  head,
  output logic            empty
);

  tcns_pkg::cmd_t slots [tcns_pkg::CMDQ_DEPTH];
  logic [tcns_pkg::CMDQ_AW-1:0] wr_ptr, rd_ptr;
  logic [tcns_pkg::CMDQ_AW:0]   count;
  logic do_push, do_pop;

  assign full    = count == (tcns_pkg::CMDQ_AW+1)'(tcns_pkg::CMDQ_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

// ===== rtl/tcns_front.sv =====
`include "three_channel_note_sequencer_top_assert.svh"

module tcns_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  tcns_pkg::in_t    item,
  input  logic [7:0]       tpb,
  input  tcns_pkg::tpb_wr_t tpb_wr,
  output logic             q_push,
  output tcns_pkg::cmd_t   q_data,
  input  logic             q_full
);

  logic       busy;
  logic [2:0] step;
  logic [7:0] dividend;
  logic [8:0] divisor, rem, rem_shift, rem_step;
  logic [7:0] tick_count, tick_rem, inc_tick, inc_rem;
  logic       accept, is_write, fire;

  assign full     = q_full || busy;
  assign accept   = push && !full;
  assign is_write = item.cmd == tcns_pkg::CMD_WRITE;
  // tick_rem tracks tick_count mod ticks_per_beat (mod 256 when zero)
  assign fire     = tick_rem == 8'd0;
  assign q_push   = accept && (is_write || fire);

  always_comb begin
    q_data         = '0;
    q_data.is_beat = !is_write;
    q_data.chan    = item.channel;
    q_data.idx     = item.beat_index;
    q_data.pitch   = item.pitch;
    q_data.duty    = item.duty;
    q_data.env     = item.envelope;
  end

  // one restoring remainder step per cycle
  assign rem_shift = {rem[7:0], dividend[7]};
  assign rem_step  = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;

  assign inc_tick = tick_count + 8'd1;
  assign inc_rem  = tick_rem + 8'd1;

  always_ff @(posedge clk) begin
    if (tpb_wr.load) begin
      dividend <= tick_count;
      divisor  <= (tpb_wr.value == 8'd0) ? 9'd256 : {1'b0, tpb_wr.value};
      rem      <= '0;
    end else if (busy) begin
      dividend <= {dividend[6:0], 1'b0};
      rem      <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      step       <= '0;
      tick_count <= '0;
      tick_rem   <= '0;
    end else if (tpb_wr.load) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 3'd1;
      if (step == 3'd7) begin
        busy     <= 1'b0;
        tick_rem <= rem_step[7:0];
      end
    end else if (accept && !is_write) begin
      if (fire) begin
        tick_count <= 8'd1;
        tick_rem   <= (inc_rem == tpb) ? 8'd0 : inc_rem;
      end else begin
        tick_count <= inc_tick;
        // counter wrap to zero lands on a beat whatever the divisor
        tick_rem   <= (inc_tick == 8'd0 || inc_rem == tpb) ? 8'd0 : inc_rem;
      end
    end
  end

  `TCNS_ASSERT_NOW(a_rem_in_range, !busy && tpb != 8'd0, tick_rem < tpb)
  `TCNS_ASSERT_NEXT(a_load_stalls, tpb_wr.load, full)

endmodule

// ===== rtl/tcns_back.sv =====
`include "three_channel_note_sequencer_top_assert.svh"

module tcns_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  tcns_pkg::cmd_t  q_head,
  output logic            q_pop,
  input  logic [7:0]      plen,
  input  logic            pop,
  output logic            empty,
  output tcns_pkg::out_t  notes
);

  localparam int OQ_CW = tcns_pkg::OUTQ_AW + 1;

  tcns_pkg::entry_t mem_t1 [tcns_pkg::PATTERN_DEPTH];
  tcns_pkg::entry_t mem_t2 [tcns_pkg::PATTERN_DEPTH];
  tcns_pkg::entry_t mem_nz [tcns_pkg::PATTERN_DEPTH];
  tcns_pkg::entry_t rd_t1, rd_t2, rd_nz, wr_entry;

  logic [tcns_pkg::PAT_AW-1:0] wr_addr, rd_addr;
  logic [6:0] beat_pos;
  logic [7:0] pos_inc;
  logic       beat_go, wr_go, s1_valid, s1_silent;

  tcns_pkg::out_t outq [tcns_pkg::OUTQ_DEPTH];
  tcns_pkg::out_t res;
  tcns_pkg::chan_out_t c1, c2, cn;
  logic [tcns_pkg::OUTQ_AW-1:0] oq_wr, oq_rd;
  logic [OQ_CW-1:0] ocount;
  logic oq_pop;

  // a beat issues only when its result is sure of a slot
  assign q_pop = !q_empty && (!q_head.is_beat ||
                 (ocount + OQ_CW'(s1_valid)) < OQ_CW'(tcns_pkg::OUTQ_DEPTH));
  assign beat_go = q_pop && q_head.is_beat;
  assign wr_go   = q_pop && !q_head.is_beat && q_head.chan <= tcns_pkg::CHAN_NOISE &&
                   32'(q_head.idx) < tcns_pkg::PATTERN_DEPTH;

  assign wr_addr  = tcns_pkg::PAT_AW'(q_head.idx);
  assign rd_addr  = tcns_pkg::PAT_AW'(beat_pos);
  assign wr_entry = '{pitch: q_head.pitch, duty: q_head.duty, env: q_head.env};
  assign pos_inc  = {1'b0, beat_pos} + 8'd1;

  always_ff @(posedge clk) begin
    if (wr_go && q_head.chan == tcns_pkg::CHAN_TONE1) mem_t1[wr_addr] <= wr_entry;
    if (wr_go && q_head.chan == tcns_pkg::CHAN_TONE2) mem_t2[wr_addr] <= wr_entry;
    if (wr_go && q_head.chan == tcns_pkg::CHAN_NOISE) mem_nz[wr_addr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (beat_go) begin
      rd_t1     <= mem_t1[rd_addr];
      rd_t2     <= mem_t2[rd_addr];
      rd_nz     <= mem_nz[rd_addr];
      s1_silent <= 32'(beat_pos) >= tcns_pkg::PATTERN_DEPTH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_pos <= '0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= beat_go;
      if (beat_go) beat_pos <= (pos_inc == plen || pos_inc[7]) ? 7'd0 : pos_inc[6:0];
    end
  end

  assign c1 = tcns_pkg::channel_out(rd_t1, s1_silent);
  assign c2 = tcns_pkg::channel_out(rd_t2, s1_silent);
  assign cn = tcns_pkg::channel_out(rd_nz, s1_silent);

  always_comb begin
    res = '{
      tone1_on: c1.on, tone1_duty: c1.duty, tone1_envelope: c1.env, tone1_freq: c1.freq,
      tone2_on: c2.on, tone2_duty: c2.duty, tone2_envelope: c2.env, tone2_freq: c2.freq,
      noise_on: cn.on, noise_length: cn.duty, noise_envelope: cn.env, noise_freq: cn.freq
    };
  end

  assign empty  = ocount == '0;
  assign oq_pop = pop && !empty;
  assign notes  = outq[oq_rd];

  always_ff @(posedge clk) begin
    if (s1_valid) outq[oq_wr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr  <= '0;
      oq_rd  <= '0;
      ocount <= '0;
    end else begin
      if (s1_valid) oq_wr <= oq_wr + 1'b1;
      if (oq_pop)   oq_rd <= oq_rd + 1'b1;
      if (s1_valid && !oq_pop) ocount <= ocount + 1'b1;
      else if (oq_pop && !s1_valid) ocount <= ocount - 1'b1;
    end
  end

  `TCNS_ASSERT_NOW(a_outq_room, s1_valid, ocount < OQ_CW'(tcns_pkg::OUTQ_DEPTH))
  `TCNS_ASSERT_NEXT(a_write_no_result, q_pop && !q_head.is_beat, !s1_valid)
  `TCNS_ASSERT_NEXT(a_pos_only_on_beat, !beat_go, $stable(beat_pos))

endmodule

// ===== test/three_channel_note_sequencer_checker.sv =====
`timescale 1ns / 100ps

module three_channel_note_sequencer_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           full,
  input  tcns_pkg::in_t  item,
  input  logic           empty,
  input  logic           pop,
  input  tcns_pkg::out_t notes,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data,
  output int             errors,
  output int             pending,
  output int             beats_checked
);
  import tcns_pkg::*;

  localparam int NOTES = 72;
  localparam logic [6:0] SILENCE = 7'd72;

  // frequency code per note, from note 0 upward
  localparam logic [10:0] PITCH_CODE [NOTES] = '{
    11'd44,   11'd156,  11'd262,  11'd363,  11'd457,  11'd547,
    11'd631,  11'd710,  11'd786,  11'd854,  11'd923,  11'd986,
    11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
    11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
    11'd1546, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
    11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
    11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
    11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
    11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
    11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
    11'd1985, 11'd1988, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
    11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015
  };

  typedef struct packed {
    logic [6:0] pitch;
    logic [7:0] duty;
    logic [7:0] env;
  } step_entry_t;

  // on, duty, envelope, freq: same layout as one channel of out_t
  typedef logic [27:0] voice_t;

  step_entry_t    pattern [3][128];
  logic [7:0]     beat_ticks;
  logic [7:0]     loop_len;
  logic [7:0]     tick_cnt;
  logic [6:0]     play_pos;
  tcns_pkg::out_t due_notes [$];
  string          voice_name [3] = '{"tone1", "tone2", "noise"};

  initial begin
    errors = 0;
    pending = 0;
    beats_checked = 0;
  end

  function automatic voice_t voice(input int ch);
    step_entry_t e;
    voice_t v;
    e = pattern[ch][play_pos];
    v = '0;
    if (e.pitch < SILENCE) v = {1'b1, e.duty, e.env, PITCH_CODE[e.pitch]};
    return v;
  endfunction

  function automatic void take_item(input tcns_pkg::in_t it);
    logic fire;
    logic [7:0] nxt;
    if (it.cmd == CMD_WRITE) begin
      if (it.channel <= CHAN_NOISE)
        pattern[it.channel][it.beat_index] = {it.pitch, it.duty, it.envelope};
    end else begin
      fire = (beat_ticks == 8'd0) ? (tick_cnt == 8'd0) : ((tick_cnt % beat_ticks) == 8'd0);
      if (!fire) begin
        tick_cnt = tick_cnt + 8'd1;
      end else begin
        due_notes.push_back({voice(0), voice(1), voice(2)});
        nxt = {1'b0, play_pos} + 8'd1;
        if (nxt == loop_len || nxt >= 8'd128) nxt = 8'd0;
        play_pos = nxt[6:0];
        tick_cnt = 8'd1;
      end
    end
  endfunction

  function automatic void compare_field(input string what, input logic [10:0] want,
                                        input logic [10:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endfunction

  function automatic void check_notes(input tcns_pkg::out_t got);
    tcns_pkg::out_t want;
    voice_t e;
    voice_t a;
    int ch;
    if (due_notes.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, got %h", $time, got);
    end else begin
      want = due_notes.pop_front();
      for (ch = 0; ch < 3; ch++) begin
        e = want[83 - 28 * ch -: 28];
        a = got[83 - 28 * ch -: 28];
        compare_field({voice_name[ch], "_on"}, 11'(e[27]), 11'(a[27]));
        compare_field({voice_name[ch], "_duty"}, 11'(e[26:19]), 11'(a[26:19]));
        compare_field({voice_name[ch], "_envelope"}, 11'(e[18:11]), 11'(a[18:11]));
        compare_field({voice_name[ch], "_freq"}, e[10:0], a[10:0]);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      beat_ticks = 8'd1;
      loop_len = 8'd1;
      tick_cnt = 8'd0;
      play_pos = 7'd0;
      due_notes.delete();
      pending <= 0;
    end else begin
      // pop first: a beat accepted at this edge cannot already be on the output
      if (pop && !empty) begin
        beats_checked++;
        check_notes(notes);
      end
      if (cfg_we) begin
        if (cfg_index == REG_TICKS_PER_BEAT) beat_ticks = cfg_data;
        else loop_len = cfg_data;
      end
      if (push && !full) take_item(item);
      pending <= due_notes.size();
    end
  end

endmodule

// ===== test/three_channel_note_sequencer_top_test.sv =====
`timescale 1ns / 100ps

module three_channel_note_sequencer_top_test;
  import tcns_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] CHAN_UNUSED = 2'd3;
  localparam logic [6:0] SILENT_PITCH = 7'd72;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       pop = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_TICKS_PER_BEAT;
  logic [7:0] cfg_data = 8'd0;
  in_t        item = '0;
  logic       full;
  logic       empty;
  out_t       notes;

  int errors;
  int pending;
  int beats_checked;

  logic calm = 1'b0;
  int   stall_left = 0;
  int   quiet_cycles = 0;
  int   n_writes = 0;
  int   n_ticks = 0;
  int   n_dropped = 0;
  int   n_settings = 0;

  // stimulus-side copy of the beat position, so no beat lands on an unwritten entry
  int seq_tpb = 1;
  int seq_len = 1;
  int seq_ticks = 0;
  int seq_pos = 0;
  bit written [3][128];

  always #2 clk = ~clk;

  three_channel_note_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .notes     (notes),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  three_channel_note_sequencer_checker beat_check (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .notes         (notes),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  // result side: random stall bursts on pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic bit beat_due();
    return (seq_ticks % seq_tpb) == 0;
  endfunction

  function automatic logic [6:0] random_pitch();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return SILENT_PITCH;
    if (r == 1) return 7'($urandom_range(73, 127));
    return 7'($urandom_range(0, 71));
  endfunction

  task automatic send(input in_t v);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    item <= v;
    do @(posedge clk); while (full);
    if (v.cmd == CMD_WRITE) begin
      if (v.channel <= CHAN_NOISE) begin
        n_writes++;
        written[v.channel][v.beat_index] = 1'b1;
      end else begin
        n_dropped++;
      end
    end else begin
      n_ticks++;
      if (beat_due()) begin
        seq_ticks = 1;
        seq_pos = (seq_pos + 1 == seq_len || seq_pos + 1 >= 128) ? 0 : seq_pos + 1;
      end else begin
        seq_ticks = (seq_ticks + 1) % 256;
      end
    end
  endtask

  task automatic write_entry(input logic [1:0] ch, input logic [6:0] idx,
                             input logic [6:0] pitch, input logic [7:0] duty,
                             input logic [7:0] env);
    in_t v;
    v.cmd = CMD_WRITE;
    v.channel = ch;
    v.beat_index = idx;
    v.pitch = pitch;
    v.duty = duty;
    v.envelope = env;
    send(v);
  endtask

  task automatic tick_once();
    in_t v;
    int ch;
    if (beat_due()) begin
      for (ch = 0; ch < 3; ch++)
        if (!written[ch][seq_pos])
          write_entry(2'(ch), 7'(seq_pos), random_pitch(), 8'($urandom), 8'($urandom));
    end
    v = in_t'($urandom);
    v.cmd = CMD_TICK;
    send(v);
  endtask

  // only while idle: all results in, then time for the pipeline to drain
  task automatic set_config(input int tpb, input int len);
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data <= 8'(len);
    @(posedge clk);
    cfg_index <= REG_TICKS_PER_BEAT;
    cfg_data <= 8'(tpb);
    @(posedge clk);
    cfg_we <= 1'b0;
    seq_tpb = tpb;
    seq_len = len;
    n_settings++;
  endtask

  task automatic run_phase(input int n, input int tick_pct);
    int start;
    int r;
    int idx;
    start = n_writes + n_ticks;
    while (n_writes + n_ticks - start < n) begin
      r = $urandom_range(0, 99);
      idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, seq_len - 1)
                                         : $urandom_range(0, 127);
      if (r < tick_pct)
        tick_once();
      else if (r < tick_pct + 4)
        write_entry(CHAN_UNUSED, 7'(idx), random_pitch(), 8'($urandom), 8'($urandom));
      else
        write_entry(2'($urandom_range(0, 2)), 7'(idx), random_pitch(),
                    8'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: every tick is a beat on position 0
    write_entry(CHAN_TONE1, 7'd0, 7'd0, 8'h00, 8'h00);
    write_entry(CHAN_TONE2, 7'd0, 7'd71, 8'hff, 8'hff);
    write_entry(CHAN_NOISE, 7'd0, SILENT_PITCH, 8'haa, 8'h55);
    tick_once();
    // unused channel is dropped; pitch above silence stays silent
    write_entry(CHAN_UNUSED, 7'd0, 7'd5, 8'h12, 8'h34);
    write_entry(CHAN_NOISE, 7'd0, 7'd127, 8'hff, 8'hff);
    write_entry(CHAN_TONE1, 7'd127, 7'd36, 8'h5a, 8'ha5);
    tick_once();
    write_entry(CHAN_NOISE, 7'd0, 7'd64, 8'h01, 8'h80);
    tick_once();

    // full-length pattern, long enough to wrap at 128
    set_config(1, 128);
    run_phase(420, 70);
    // short pattern while the position may sit past its end
    set_config(3, 7);
    run_phase(130, 55);
    set_config(255, 2);
    run_phase(280, 97);
    set_config(2, 1);
    run_phase(60, 50);
    set_config($urandom_range(1, 16), $urandom_range(1, 128));
    run_phase(60, 50);
    calm <= 1'b1;
    set_config(1, 4);
    run_phase(60, 50);

    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Sent %0d pattern writes, %0d ticks and %0d writes to the unused channel;",
             n_writes, n_ticks, n_dropped);
    $display("checked %0d beats across %0d register settings.", beats_checked, n_settings);
    if (errors == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
